### rtl/block_table_first_fit_allocator_unit_macros.svh
// Assertion macros shared by the allocator's top level.
`ifndef BLOCK_TABLE_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define BLOCK_TABLE_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFA_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen outside of reset.
`define BFA_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

### rtl/bfa_pkg.sv
// Shared types, codes and defaults of the first-fit block allocator.
package bfa_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int ADDR_WIDTH_DEF = 32;

  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int BIU_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END  = 2'd1;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load_item;
    logic                start_search;
    logic                idx_clear;
    logic                idx_inc;
    logic                idx_last;
    logic                capture_slot;
    logic                div_start;
    logic                jump;
    logic                commit_alloc;
    logic                commit_move;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_release;
    logic size_zero;
    logic table_full;
    logic region_bad;
    logic cand_past;
    logic iter_done;
    logic table_empty;
    logic idx_last;
    logic hit;
    logic jump_fail;
    logic div_done;
  } sts_t;

endpackage

### rtl/block_table_first_fit_allocator_unit.sv
// Top level of the first-fit block allocator.
// The unit keeps a table of up to MAX_BLOCKS allocated blocks and works on one
// request at a time; the next request is taken while the previous result still
// waits in the output register. The table sits in a single-read memory, so each
// entry is read into a register before it is checked. A release scans the
// entries for the matching one. An allocate tries candidates from the region
// base, checks each against the entries and jumps past a colliding block, which
// goes through the bit-serial remainder unit. Configuration writes are
// always taken and belong in idle periods only.
`include "block_table_first_fit_allocator_unit_macros.svh"

module block_table_first_fit_allocator_unit #(
  parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_WIDTH = bfa_pkg::ADDR_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfa_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [bfa_pkg::DATA_W-1:0]    req_size,
  input  logic [bfa_pkg::DATA_W-1:0]    release_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfa_pkg::DATA_W-1:0]    block_addr,
  output logic [bfa_pkg::STATUS_W-1:0]  status,
  output logic [bfa_pkg::BIU_W-1:0]     blocks_in_use,
  output logic [bfa_pkg::DATA_W-1:0]    bytes_used,
  output logic [bfa_pkg::DATA_W-1:0]    bytes_free
);

  bfa_pkg::cmd_t cmd;
  bfa_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_func         (func),
    .in_req_size     (req_size),
    .in_release_addr (release_addr),
    .cmd             (cmd),
    .sts             (sts),
    .block_addr      (block_addr),
    .status          (status),
    .blocks_in_use   (blocks_in_use),
    .bytes_used      (bytes_used),
    .bytes_free      (bytes_free)
  );

  // A new result must never overwrite one that has not been taken.
  `BFA_ASSERT_IMPLIES(a_no_result_overwrite, cmd.res_load, !out_valid || out_ready, "result overwritten")
  // An allocation is never appended to a full table.
  `BFA_ASSERT_IMPLIES(a_no_alloc_when_full, cmd.commit_alloc, !sts.table_full, "append to full table")
  // A release never moves an entry out of an empty table.
  `BFA_ASSERT_NEVER(a_no_move_when_empty, cmd.commit_move && sts.table_empty, "move on empty table")
  // Only an allocate search uses the remainder unit.
  `BFA_ASSERT_IMPLIES(a_div_only_alloc, cmd.div_start, !sts.is_release, "divide during release")

endmodule

### rtl/bfa_div.sv
// Bit-serial restoring divider that returns the remainder.
module bfa_div #(
  parameter int W = bfa_pkg::ADDR_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] rem
);

  localparam int CNW = $clog2(W + 1);

  logic [W-1:0]   acc;
  logic [W-1:0]   quo;
  logic [CNW-1:0] cnt;
  logic [W:0]     rem_sh;
  logic [W:0]     rem_diff;
  logic           ge;
  logic [W-1:0]   acc_next;

  always_comb begin
    rem_sh   = {acc, quo[W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    ge       = rem_sh >= {1'b0, divisor};
    // The partial remainder stays below the divisor, so W bits hold it.
    acc_next = ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNW'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNW'(1);
        if (cnt == CNW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      quo <= dividend;
    end else if (cnt != '0) begin
      acc <= acc_next;
      quo <= {quo[W-2:0], 1'b0};
    end
  end

  assign rem = acc;

endmodule

### rtl/bfa_ctrl.sv
// Controller state machine of the allocator.
module bfa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bfa_pkg::sts_t sts,
  output bfa_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_CAND  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_TST   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_MVRD  = 4'd6;
  localparam logic [3:0] S_MVTST = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]                   state;
  logic [3:0]                   state_next;
  logic [bfa_pkg::STATUS_W-1:0] res_code;
  logic [bfa_pkg::STATUS_W-1:0] res_code_next;
  logic                         out_valid_next;

  always_comb begin
    state_next     = state;
    res_code_next  = res_code;
    cmd            = '0;
    cmd.res_status = res_code;
    in_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_release) begin
          if (sts.table_empty) begin
            res_code_next = bfa_pkg::ST_NOT_FOUND;
            state_next    = S_DONE;
          end else begin
            cmd.idx_clear = 1'b1;
            state_next    = S_RD;
          end
        end else if (sts.size_zero) begin
          res_code_next = bfa_pkg::ST_ZERO_SIZE;
          state_next    = S_DONE;
        end else if (sts.table_full) begin
          res_code_next = bfa_pkg::ST_TABLE_FULL;
          state_next    = S_DONE;
        end else if (sts.region_bad) begin
          res_code_next = bfa_pkg::ST_NO_SPACE;
          state_next    = S_DONE;
        end else begin
          cmd.start_search = 1'b1;
          state_next       = S_CAND;
        end
      end
      S_CAND: begin
        if (sts.iter_done || sts.cand_past) begin
          res_code_next = bfa_pkg::ST_NO_SPACE;
          state_next    = S_DONE;
        end else if (sts.table_empty) begin
          cmd.commit_alloc = 1'b1;
          res_code_next    = bfa_pkg::ST_OK;
          state_next       = S_DONE;
        end else begin
          cmd.idx_clear = 1'b1;
          state_next    = S_RD;
        end
      end
      S_RD: begin
        state_next = S_TST;
      end
      S_TST: begin
        if (sts.hit) begin
          if (sts.is_release) begin
            cmd.capture_slot = 1'b1;
            cmd.idx_last     = 1'b1;
            state_next       = S_MVRD;
          end else if (sts.jump_fail) begin
            res_code_next = bfa_pkg::ST_NO_SPACE;
            state_next    = S_DONE;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end else if (sts.idx_last) begin
          if (sts.is_release) begin
            res_code_next = bfa_pkg::ST_NOT_FOUND;
          end else begin
            cmd.commit_alloc = 1'b1;
            res_code_next    = bfa_pkg::ST_OK;
          end
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_RD;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.jump   = 1'b1;
          state_next = S_CAND;
        end
      end
      S_MVRD: begin
        state_next = S_MVTST;
      end
      S_MVTST: begin
        cmd.commit_move = 1'b1;
        res_code_next   = bfa_pkg::ST_OK;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_code <= res_code_next;
  end

endmodule

### rtl/bfa_dp.sv
// Datapath of the allocator: block table, search registers and totals.
module bfa_dp #(
  parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_WIDTH = bfa_pkg::ADDR_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfa_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          in_func,
  input  logic [bfa_pkg::DATA_W-1:0]    in_req_size,
  input  logic [bfa_pkg::DATA_W-1:0]    in_release_addr,
  input  bfa_pkg::cmd_t                 cmd,
  output bfa_pkg::sts_t                 sts,
  output logic [bfa_pkg::DATA_W-1:0]    block_addr,
  output logic [bfa_pkg::STATUS_W-1:0]  status,
  output logic [bfa_pkg::BIU_W-1:0]     blocks_in_use,
  output logic [bfa_pkg::DATA_W-1:0]    bytes_used,
  output logic [bfa_pkg::DATA_W-1:0]    bytes_free
);

  localparam int AW = ADDR_WIDTH;
  localparam int DW = bfa_pkg::DATA_W;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int TW = $clog2(MAX_BLOCKS + 3);
  localparam int XW = (AW > DW) ? AW : DW;

  logic [AW-1:0] region_base;
  logic [AW-1:0] region_end;
  logic          func_rel;
  logic [AW-1:0] size;
  logic [AW-1:0] raddr;
  logic [AW-1:0] cand;
  logic [TW-1:0] iter;
  logic [IW-1:0] idx;
  logic [IW-1:0] slot;
  logic [CW-1:0] count;
  logic [DW-1:0] used;
  logic [AW-1:0] span_end;

  logic [AW-1:0] entry_start [MAX_BLOCKS];
  logic [AW-1:0] entry_size  [MAX_BLOCKS];
  logic [AW-1:0] q_start;
  logic [AW-1:0] q_size;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [AW-1:0] mem_wstart;
  logic [AW-1:0] mem_wsize;

  logic [AW-1:0] lim;
  logic          overlap;
  logic [AW:0]   span_sum;
  logic [AW-1:0] dividend;
  logic          div_done;
  logic [AW-1:0] div_rem;
  logic [AW-1:0] region_size;
  logic [XW-1:0] rsize_x;
  logic [XW-1:0] used_x;
  logic [XW-1:0] free_x;

  // Largest candidate start that still ends inside the region.
  assign lim = region_end - size;

  always_comb begin
    // A candidate collides with an entry if it touches [start, start + size].
    if (cand >= q_start) begin
      overlap = (cand - q_start) <= q_size;
    end else begin
      overlap = (q_start - cand) <= (size - AW'(1));
    end
    span_sum = {1'b0, q_start} + {1'b0, q_size};
    dividend = span_sum[AW-1:0] - cand;
  end

  always_comb begin
    sts.is_release  = func_rel;
    sts.size_zero   = size == '0;
    sts.table_full  = count == CW'(MAX_BLOCKS);
    sts.region_bad  = (region_base > region_end) || ((region_end - region_base) < size);
    sts.cand_past   = cand > lim;
    sts.iter_done   = iter == TW'(MAX_BLOCKS + 2);
    sts.table_empty = count == '0;
    sts.idx_last    = CW'(idx) == (count - CW'(1));
    sts.hit         = func_rel ? (q_start == raddr) : overlap;
    // No later candidate fits once the entry's span reaches the limit.
    sts.jump_fail   = span_sum >= {1'b0, lim};
    sts.div_done    = div_done;
  end

  bfa_div #(
    .W (AW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (size),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    mem_we = cmd.commit_alloc || cmd.commit_move;
    if (cmd.commit_move) begin
      mem_waddr  = slot;
      mem_wstart = q_start;
      mem_wsize  = q_size;
    end else begin
      mem_waddr  = count[IW-1:0];
      mem_wstart = cand;
      mem_wsize  = size;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_start[mem_waddr] <= mem_wstart;
      entry_size[mem_waddr]  <= mem_wsize;
    end
    q_start <= entry_start[idx];
    q_size  <= entry_size[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      region_end  <= '0;
      count       <= '0;
      used        <= '0;
    end else begin
      if (cfg_we && (cfg_index == bfa_pkg::REG_REGION_BASE)) begin
        region_base <= AW'(cfg_data);
      end
      if (cfg_we && (cfg_index == bfa_pkg::REG_REGION_END)) begin
        region_end <= AW'(cfg_data);
      end
      if (cmd.commit_alloc) begin
        count <= count + CW'(1);
        used  <= used + DW'(size);
      end else if (cmd.commit_move) begin
        count <= count - CW'(1);
      end
      if (cmd.capture_slot) begin
        used <= used - DW'(q_size);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_rel <= in_func == bfa_pkg::FUNC_RELEASE;
      size     <= AW'(in_req_size);
      raddr    <= AW'(in_release_addr);
    end
    if (cmd.start_search) begin
      cand <= region_base;
      iter <= '0;
    end else if (cmd.jump) begin
      // First candidate strictly above the colliding span.
      cand <= span_end + size - div_rem;
      iter <= iter + TW'(1);
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end else if (cmd.idx_last) begin
      idx <= IW'(count - CW'(1));
    end
    if (cmd.capture_slot) begin
      slot <= idx;
    end
    if (cmd.div_start) begin
      span_end <= span_sum[AW-1:0];
    end
  end

  always_comb begin
    region_size = (region_end > region_base) ? (region_end - region_base) : '0;
    rsize_x     = XW'(region_size);
    used_x      = XW'(used);
    free_x      = (rsize_x > used_x) ? (rsize_x - used_x) : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if ((cmd.res_status == bfa_pkg::ST_OK) && !func_rel) begin
        block_addr <= DW'(cand);
      end else begin
        block_addr <= '0;
      end
      status        <= cmd.res_status;
      blocks_in_use <= bfa_pkg::BIU_W'(count);
      bytes_used    <= used;
      bytes_free    <= DW'(free_x);
    end
  end

endmodule
